### rtl/secb_pkg.sv
// secb_pkg: shared constants, codes and types of the saturating event counter bank.
// No dependencies; imported by every module of the block but secb_ram.
`default_nettype none

package secb_pkg;

  localparam int EVENTS = 64;
  localparam int CPUS   = 8;

  // Fixed field widths of the stream payload
  localparam int EV_FW  = 6;
  localparam int CPU_FW = 3;
  localparam int OP_FW  = 2;

  // Memory address widths
  localparam int EV_AW  = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int CPU_AW = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int PC_AW  = CPU_AW + EV_AW;

  localparam int COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 31'h7fffffff;

  typedef enum logic [OP_FW-1:0] {
    OP_RECORD = 2'd0,
    OP_TOTAL  = 2'd1,
    OP_CPU    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SUM,
    S_DONE
  } state_t;

  // Requests to the shared and per-CPU counter memories
  typedef struct packed {
    logic               sh_we;
    logic [EV_AW-1:0]   sh_addr;
    logic               pc_we;
    logic [PC_AW-1:0]   pc_addr;
    logic [COUNT_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               read_error;
  } result_t;

endpackage

`default_nettype wire

### rtl/secb_ram.sv
// secb_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module secb_ram #(
  parameter int AW = 6,
  parameter int DW = 31
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### rtl/secb_ctrl.sv
// secb_ctrl: sequencer for the counter bank: clear sweep, read-modify-write of
// counters and the per-CPU summing walk. Depends on secb_pkg.
`default_nettype none

module secb_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            per_cpu_split,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [secb_pkg::OP_FW-1:0]      in_op,
  input  wire logic [secb_pkg::EV_FW-1:0]      in_ev,
  input  wire logic [secb_pkg::CPU_FW-1:0]     in_cpu,
  input  wire logic [secb_pkg::COUNT_W-1:0]    sh_rdata,
  input  wire logic [secb_pkg::COUNT_W-1:0]    pc_rdata,
  output secb_pkg::mem_req_t                   mem,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output secb_pkg::result_t                    res
);

  import secb_pkg::*;

  state_t             state;
  state_t             state_next;
  op_t                op_q;
  logic [EV_AW-1:0]   ev_q;
  logic [CPU_AW-1:0]  cpu_q;
  logic               split_q;
  logic               err_q;
  logic [COUNT_W-1:0] value_q;
  logic [CPU_AW-1:0]  idx;
  logic [PC_AW-1:0]   clr;

  logic               ev_ok;
  logic               cpu_ok;
  logic               in_err;
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] sum_sat;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] bumped;
  logic [CPU_AW-1:0]  sel_cpu;

  assign ev_ok  = (in_ev != '0) && ({1'b0, in_ev} < (EV_FW+1)'(EVENTS));
  assign cpu_ok = {1'b0, in_cpu} < (CPU_FW+1)'(CPUS);

  // Error outcome of a read decided at accept
  always_comb begin
    case (op_t'(in_op))
      OP_TOTAL: in_err = !ev_ok;
      OP_CPU:   in_err = !(ev_ok && cpu_ok && per_cpu_split);
      default:  in_err = 1'b0;
    endcase
  end

  assign sum_wide = {1'b0, value_q} + {1'b0, pc_rdata};
  assign sum_sat  = sum_wide[COUNT_W] ? COUNT_LIMIT : sum_wide[COUNT_W-1:0];
  assign cur      = split_q ? pc_rdata : sh_rdata;
  assign bumped   = (cur == COUNT_LIMIT) ? cur : cur + 1'b1;
  assign sel_cpu  = (op_t'(in_op) == OP_TOTAL) ? '0 : CPU_AW'(in_cpu);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_op))
            OP_RECORD: begin
              if (ev_ok && (!per_cpu_split || cpu_ok)) state_next = S_LOOKUP;
            end
            OP_TOTAL: begin
              if (!ev_ok) state_next = S_DONE;
              else if (per_cpu_split) state_next = S_SUM;
              else state_next = S_LOOKUP;
            end
            OP_CPU: begin
              state_next = in_err ? S_DONE : S_LOOKUP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: begin
        state_next = (op_q == OP_RECORD) ? S_IDLE : S_DONE;
      end
      S_SUM: begin
        if (idx == CPU_AW'(CPUS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and memory requests
  always_comb begin
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem.sh_we    = 1'b0;
    mem.pc_we    = 1'b0;
    mem.sh_addr  = ev_q;
    mem.pc_addr  = {cpu_q, ev_q};
    mem.wdata    = bumped;
    case (state)
      S_CLEAR: begin
        mem.sh_we   = 1'b1;
        mem.pc_we   = 1'b1;
        mem.sh_addr = clr[EV_AW-1:0];
        mem.pc_addr = clr;
        mem.wdata   = '0;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        mem.sh_addr = EV_AW'(in_ev);
        mem.pc_addr = {sel_cpu, EV_AW'(in_ev)};
      end
      S_LOOKUP: begin
        mem.sh_we = (op_q == OP_RECORD) && !split_q;
        mem.pc_we = (op_q == OP_RECORD) && split_q;
      end
      S_SUM: begin
        mem.pc_addr = {CPU_AW'(idx + 1'b1), ev_q};
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign res.count_value = value_q;
  assign res.read_error  = err_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_q    <= op_t'(in_op);
        ev_q    <= EV_AW'(in_ev);
        cpu_q   <= sel_cpu;
        split_q <= per_cpu_split;
        err_q   <= in_err;
        value_q <= '0;
        idx     <= '0;
      end
      S_LOOKUP: begin
        value_q <= (op_q == OP_TOTAL) ? sh_rdata : pc_rdata;
      end
      S_SUM: begin
        value_q <= sum_sat;
        idx     <= CPU_AW'(idx + 1'b1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/secb_outreg.sv
// secb_outreg: output register of the result stream; frees the sequencer while
// a finished result waits. Depends on secb_pkg.
`default_nettype none

module secb_outreg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  secb_pkg::result_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output secb_pkg::result_t out_data
);

  import secb_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= in_data;
  end

endmodule

`default_nettype wire

### rtl/saturating_event_counter_bank.sv
// Record: read-modify-write via the lookup state. Shared total or per-CPU read: a lookup,
// then to the output register. Per-CPU total: a summing walk, one counter per cycle from
// the per-CPU memory port. One transaction in flight; results wait in an output register.
// Reset: mode register to per-CPU, then a clearing pass over both memories
// (one address per cycle, shared set on the low address bits); s_tready stays low meanwhile.
// Depends on secb_pkg, secb_ram, secb_ctrl, secb_outreg.
`default_nettype none

module saturating_event_counter_bank (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: per_cpu_split
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // Command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [5:0] event_number, [8:6] cpu_index, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [30:0] count_value, [31] zero
  output logic             m_tuser    // [0] read_error
);

  import secb_pkg::*;

  logic               per_cpu_split;
  mem_req_t           mem;
  logic [COUNT_W-1:0] sh_rdata;
  logic [COUNT_W-1:0] pc_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            res_out;

  // Mode register: to be written only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      per_cpu_split <= 1'b1;
    end else if (cfg_we) begin
      per_cpu_split <= cfg_wdata;
    end
  end

  secb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .per_cpu_split (per_cpu_split),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_op         (s_tuser),
    .in_ev         (s_tdata[5:0]),
    .in_cpu        (s_tdata[8:6]),
    .sh_rdata      (sh_rdata),
    .pc_rdata      (pc_rdata),
    .mem           (mem),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // Shared counter set, one word per event
  secb_ram #(
    .AW (EV_AW),
    .DW (COUNT_W)
  ) u_shared (
    .clk   (clk),
    .we    (mem.sh_we),
    .addr  (mem.sh_addr),
    .wdata (mem.wdata),
    .rdata (sh_rdata)
  );

  // Per-CPU counter sets, addressed {cpu, event}
  secb_ram #(
    .AW (PC_AW),
    .DW (COUNT_W)
  ) u_per_cpu (
    .clk   (clk),
    .we    (mem.pc_we),
    .addr  (mem.pc_addr),
    .wdata (mem.wdata),
    .rdata (pc_rdata)
  );

  secb_outreg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_out)
  );

  assign m_tdata = {1'b0, res_out.count_value};
  assign m_tuser = res_out.read_error;

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for saturating_event_counter_bank.
// Directed table, then random command traffic; reads are scored against an in-bench counter model.
// Depends on secb_pkg and the RTL of the block.
`default_nettype none

module tb_top;
  import secb_pkg::*;

  // Opcode 3 has no enum member in the package; the block drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam bit MODE_SHARED  = 1'b0;
  localparam bit MODE_PER_CPU = 1'b1;

  // Longest path is a per-CPU total; records leave no result, so after the last
  // read we still let the block go quiet before a mode write.
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 3;
  localparam int BATCHES       = 5;
  localparam int BATCH_ITEMS   = 110;
  localparam int TIMEOUT       = 3_200_000;

  // One row of the directed table. fixed=1 means the expected read is typed
  // in the row; otherwise the counter model supplies it.
  typedef struct packed {
    bit                 mode;
    logic [1:0]         op;
    logic [EV_FW-1:0]   ev;
    logic [CPU_FW-1:0]  cpu;
    bit                 fixed;
    logic [COUNT_W-1:0] want_count;
    bit                 want_err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [5:0] event_number, [8:6] cpu_index, rest zero
  logic [1:0]  s_tuser = '0;    // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [30:0] count_value, [31] zero
  logic        m_tuser;         // [0] read_error

  // Counter model state
  bit                 split_mode;
  logic [COUNT_W-1:0] shared_cnt [EVENTS];
  logic [COUNT_W-1:0] cpu_cnt    [CPUS][EVENTS];

  result_t pending_reads [$];   // reads accepted, result not yet seen
  bit      failed = 1'b0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;

  always #4 clk = ~clk;

  saturating_event_counter_bank u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Counter model: apply one accepted command, tell whether it produces a
  // read result and what that result is.
  task automatic predict_counter_read(input logic [1:0] op, input logic [EV_FW-1:0] ev,
                                      input logic [CPU_FW-1:0] cpu, output bit produces,
                                      output result_t res);
    bit          ev_ok;
    bit          cpu_ok;
    logic [33:0] sum;
    ev_ok  = (ev != '0) && (int'(ev) < EVENTS);
    cpu_ok = int'(cpu) < CPUS;
    produces = 1'b0;
    res = '0;
    case (op)
      OP_RECORD: begin
        // invalid events are dropped; cpu_index only matters in per-CPU mode
        if (ev_ok) begin
          if (split_mode == MODE_PER_CPU) begin
            if (cpu_ok && cpu_cnt[cpu][ev] != COUNT_LIMIT)
              cpu_cnt[cpu][ev] = cpu_cnt[cpu][ev] + 1'b1;
          end else if (shared_cnt[ev] != COUNT_LIMIT) begin
            shared_cnt[ev] = shared_cnt[ev] + 1'b1;
          end
        end
      end
      OP_TOTAL: begin
        produces = 1'b1;
        if (!ev_ok) begin
          res.read_error = 1'b1;
        end else if (split_mode == MODE_PER_CPU) begin
          sum = '0;
          for (int i = 0; i < CPUS; i++) begin
            sum = sum + cpu_cnt[i][ev];
            if (sum > COUNT_LIMIT) sum = COUNT_LIMIT;
          end
          res.count_value = sum[COUNT_W-1:0];
        end else begin
          res.count_value = shared_cnt[ev];
        end
      end
      OP_CPU: begin
        produces = 1'b1;
        // per-CPU read is an error in shared mode
        if (!ev_ok || !cpu_ok || split_mode == MODE_SHARED) res.read_error = 1'b1;
        else res.count_value = cpu_cnt[cpu][ev];
      end
      default: ;  // unused opcode: dropped
    endcase
  endtask

  // Offer one command transaction. Called at a rising edge; returns at the
  // edge where the block took it. tvalid stays high for a back-to-back item.
  task automatic send_cmd(input logic [1:0] op, input logic [EV_FW-1:0] ev,
                          input logic [CPU_FW-1:0] cpu, input bit fixed,
                          input logic [COUNT_W-1:0] want_count, input bit want_err);
    bit      produces;
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, cpu, ev};
    s_tuser  <= op;
    // inputs and tready are stable at the falling edge
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    predict_counter_read(op, ev, cpu, produces, res);
    if (produces) begin
      if (fixed) begin
        res.count_value = want_count;
        res.read_error  = want_err;
      end
      pending_reads.push_back(res);
    end
  endtask

  // Sender goes quiet until every read has come back and the block is idle.
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode register write; only called while the block is idle.
  task automatic write_mode(input bit mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_mode = mode;
  endtask

  // Result side: random backpressure, plus one long hold-off on request so
  // the output register fills and the command side stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: a result transaction completes at the next rising edge when
  // both tvalid and tready are seen high at the falling edge.
  always @(negedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual count_value=%0d read_error=%0b",
                 $time, m_tdata[30:0], m_tuser);
        failed = 1'b1;
      end else begin
        want = pending_reads.pop_front();
        if (m_tdata[30:0] !== want.count_value) begin
          $display("%0t: count_value mismatch: expected %0d, actual %0d",
                   $time, want.count_value, m_tdata[30:0]);
          failed = 1'b1;
        end
        if (m_tdata[31] !== 1'b0) begin
          $display("%0t: m_tdata[31] mismatch: expected 0, actual %b", $time, m_tdata[31]);
          failed = 1'b1;
        end
        if (m_tuser !== want.read_error) begin
          $display("%0t: read_error mismatch: expected %0b, actual %b",
                   $time, want.read_error, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t           dir_rows [$];
    dir_row_t           row;
    logic [1:0]         op;
    logic [EV_FW-1:0]   ev;
    int                 pick;

    // model reset: per-CPU mode, all counters zero
    split_mode = MODE_PER_CPU;
    for (int e = 0; e < EVENTS; e++) begin
      shared_cnt[e] = '0;
      for (int c = 0; c < CPUS; c++) cpu_cnt[c][e] = '0;
    end

    // mode, opcode, event, cpu, fixed, count, error
    dir_rows.push_back('{MODE_PER_CPU, OP_TOTAL,  6'd5,  3'd0, 1'b1, 31'd0, 1'b0}); // fresh
    dir_rows.push_back('{MODE_PER_CPU, OP_CPU,    6'd63, 3'd7, 1'b1, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_TOTAL,  6'd0,  3'd0, 1'b1, 31'd0, 1'b1}); // bad event
    dir_rows.push_back('{MODE_PER_CPU, OP_CPU,    6'd0,  3'd3, 1'b1, 31'd0, 1'b1});
    dir_rows.push_back('{MODE_PER_CPU, OP_RECORD, 6'd0,  3'd1, 1'b0, 31'd0, 1'b0}); // dropped
    dir_rows.push_back('{MODE_PER_CPU, OP_RECORD, 6'd63, 3'd7, 1'b0, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_RECORD, 6'd63, 3'd0, 1'b0, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_RECORD, 6'd1,  3'd7, 1'b0, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_CPU,    6'd63, 3'd7, 1'b1, 31'd1, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_TOTAL,  6'd63, 3'd4, 1'b1, 31'd2, 1'b0}); // sum
    dir_rows.push_back('{MODE_PER_CPU, OP_UNUSED, 6'd63, 3'd7, 1'b0, 31'd0, 1'b0}); // dropped
    dir_rows.push_back('{MODE_PER_CPU, OP_TOTAL,  6'd1,  3'd0, 1'b0, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_SHARED,  OP_CPU,    6'd63, 3'd7, 1'b1, 31'd0, 1'b1}); // no split
    dir_rows.push_back('{MODE_SHARED,  OP_TOTAL,  6'd63, 3'd0, 1'b1, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_SHARED,  OP_RECORD, 6'd63, 3'd5, 1'b0, 31'd0, 1'b0});
    dir_rows.push_back('{MODE_SHARED,  OP_RECORD, 6'd63, 3'd2, 1'b0, 31'd0, 1'b0}); // cpu moot
    dir_rows.push_back('{MODE_SHARED,  OP_TOTAL,  6'd63, 3'd7, 1'b1, 31'd2, 1'b0});
    dir_rows.push_back('{MODE_SHARED,  OP_TOTAL,  6'd0,  3'd7, 1'b1, 31'd0, 1'b1});
    dir_rows.push_back('{MODE_SHARED,  OP_UNUSED, 6'd0,  3'd0, 1'b0, 31'd0, 1'b0});
    // back to per-CPU: that set kept its values across the mode change
    dir_rows.push_back('{MODE_PER_CPU, OP_TOTAL,  6'd63, 3'd0, 1'b1, 31'd2, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_CPU,    6'd1,  3'd7, 1'b1, 31'd1, 1'b0});
    dir_rows.push_back('{MODE_PER_CPU, OP_CPU,    6'd63, 3'd3, 1'b0, 31'd0, 1'b0});

    // Synchronous reset; the block then runs its clearing pass with
    // s_tready low, which the handshake waits absorb.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: sender 8% idle, receiver 73% idle
    send_idle_pct = 8;
    recv_idle_pct = 73;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mode != split_mode) begin
        pause_until_drained();
        write_mode(row.mode);
      end
      send_cmd(row.op, row.ev, row.cpu, row.fixed, row.want_count, row.want_err);
    end

    // Random part: three idling phases, each split into batches with a mode
    // write between them. Events mostly come from a small pool so counters
    // grow; the rest covers the edges and the whole field.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 8;  recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < BATCHES; b++) begin
        pause_until_drained();
        write_mode(1'($urandom_range(1)));
        if (b == 1) hold_req = 1'b1;
        for (int n = 0; n < BATCH_ITEMS; n++) begin
          pick = $urandom_range(99);
          if (pick < 50) op = OP_RECORD;
          else if (pick < 72) op = OP_TOTAL;
          else if (pick < 95) op = OP_CPU;
          else op = OP_UNUSED;
          pick = $urandom_range(99);
          if (pick < 60) ev = EV_FW'($urandom_range(1, 3));
          else if (pick < 70) ev = EV_FW'(EVENTS - 1);
          else if (pick < 75) ev = '0;
          else ev = EV_FW'($urandom_range(EVENTS - 1));
          send_cmd(op, ev, CPU_FW'($urandom_range(CPUS - 1)), 1'b0, '0, 1'b0);
        end
      end
    end

    // wait for the last reads, then let the block go quiet
    pause_until_drained();
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### saturating_event_counter_bank.f
rtl/secb_pkg.sv
rtl/secb_ram.sv
rtl/secb_ctrl.sv
rtl/secb_outreg.sv
rtl/saturating_event_counter_bank.sv
tb/tb_top.sv
